FILE: rtl/core/fba_pkg.sv
// fba_pkg: shared types, codes and widths of the fit-policy block allocator.
// No dependencies; every other file of the allocator but fba_ram imports it.
package fba_pkg;

	// Fixed widths of the channel fields and the configuration port
	localparam int BLK_IDX_W  = 6;
	localparam int SIZE_IN_W  = 16;
	localparam int NUMBLK_W   = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	// Defaults for the top-level parameters
	localparam int MAX_BLOCKS_DEF = 64;
	localparam int SIZE_WIDTH_DEF = 16;

	localparam logic [NUMBLK_W-1:0] NUM_BLOCKS_RST = 7'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLICY     = 1'b0,
		REG_NUM_BLOCKS = 1'b1
	} fba_reg_t;

	typedef enum logic [1:0] {
		POL_BEST  = 2'd0,
		POL_FIRST = 2'd1,
		POL_WORST = 2'd2,
		POL_NEXT  = 2'd3
	} fba_policy_t;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_ALLOC = 1'b1
	} fba_req_t;

	typedef enum logic [1:0] {
		STAT_LOADED  = 2'd0,
		STAT_GRANTED = 2'd1,
		STAT_MISS    = 2'd2
	} fba_status_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_MARK = 4'b0100,
		S_RESP = 4'b1000
	} fba_state_t;

	// Verdict of the shared compare unit on one table entry
	typedef struct packed {
		logic fit;     // free and large enough
		logic better;  // beats the current candidate under the policy
	} fba_fit_t;

endpackage

FILE: rtl/core/fba_ifs.sv
// fba_ifs: valid/ready channel interfaces for request and response words.
// Depends on fba_pkg for field widths and codes.
interface fba_req_if import fba_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	logic [BLK_IDX_W-1:0] block_index;
	logic [SIZE_IN_W-1:0] block_size_in;
	logic [SIZE_IN_W-1:0] request_size;

	modport source (output valid, req_type, block_index, block_size_in, request_size,
		input ready);
	modport sink (input valid, req_type, block_index, block_size_in, request_size,
		output ready);
endinterface

interface fba_rsp_if import fba_pkg::*; ();
	logic                 valid;
	logic                 ready;
	fba_status_t          status;
	logic [BLK_IDX_W-1:0] granted_block;

	modport source (output valid, status, granted_block, input ready);
	modport sink (input valid, status, granted_block, output ready);
endinterface

FILE: rtl/core/fit_policy_block_allocator_top.sv
// fit_policy_block_allocator_top: block table allocator, four fit policies.
// Depends on fba_pkg, fba_ifs, fba_ram and fba_fit_unit.
//
//  channel   dir  handshake          word
//  req_ch    in   valid/ready        req_type, block_index, block_size_in, request_size
//  rsp_ch    out  valid/ready        status, granted_block
//  cfg       in   cfg_we (no stall)  cfg_index, cfg_data
//
// A load passes from accept through S_RESP to the output register, then S_IDLE.
// An allocate reads the table one entry per cycle through the single RAM read
// port; the scan covers all n entries (best/worst fit, or a miss), fewer when
// first/next fit hits early, n being num_blocks capped at MAX_BLOCKS.
// Reset clears control state only.
// A new word is taken while a finished result waits in the output register.
module fit_policy_block_allocator_top import fba_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fba_req_if.sink               req_ch,
	fba_rsp_if.source             rsp_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CW    = (IDX_W + 1 > NUMBLK_W) ? IDX_W + 1 : NUMBLK_W;
	localparam int RAM_W = SIZE_WIDTH + 1;

	fba_state_t            state_q;
	fba_policy_t           policy_q;
	logic [NUMBLK_W-1:0]   num_blocks_q;
	logic [BLK_IDX_W-1:0]  lgi_q;
	logic                  lgv_q;
	logic                  found_q;
	logic                  rd_pend_s1;
	logic [CW-1:0]         issue_cnt_q;
	logic                  out_vld_q;

	logic [SIZE_WIDTH-1:0] req_size_q;
	logic [CW-1:0]         n_q;
	logic [IDX_W-1:0]      addr_q;
	logic [IDX_W-1:0]      rd_addr_s1;
	logic [IDX_W-1:0]      pick_q;
	logic [SIZE_WIDTH-1:0] pick_size_q;
	logic [SIZE_WIDTH-1:0] best_left_q;
	fba_status_t           res_status_q;
	logic [BLK_IDX_W-1:0]  res_block_q;
	fba_status_t           out_status_q;
	logic [BLK_IDX_W-1:0]  out_block_q;

	logic                  accept;
	logic                  load_acc;
	logic [CW-1:0]         nb_ext;
	logic [CW-1:0]         n_calc;
	logic [CW-1:0]         lg_next;
	logic [IDX_W-1:0]      start_addr;
	logic [IDX_W-1:0]      addr_nxt;
	logic                  first_mode;
	logic                  stop_hit;
	logic                  issue;
	logic                  eval;
	logic                  scan_end;
	logic                  upd;
	logic                  rsp_load;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [RAM_W-1:0]      ram_wdata;
	logic [RAM_W-1:0]      ram_rdata;

	fba_fit_t              verdict;
	logic [SIZE_WIDTH-1:0] left;

	assign req_ch.ready = (state_q == S_IDLE);
	assign accept       = req_ch.valid && req_ch.ready;
	assign load_acc     = accept && (req_ch.req_type == REQ_LOAD);

	assign nb_ext = CW'(num_blocks_q);
	assign n_calc = (nb_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : nb_ext;

	// next fit resumes after the last grant, unless that lies past the used range
	assign lg_next    = CW'(lgi_q) + CW'(1);
	assign start_addr = (lgv_q && (lg_next < n_calc)) ? IDX_W'(lg_next) : '0;
	assign addr_nxt   = ((CW'(addr_q) + CW'(1)) == n_q) ? '0 : addr_q + IDX_W'(1);

	assign first_mode = (policy_q == POL_FIRST) || (policy_q == POL_NEXT);
	assign stop_hit   = first_mode && found_q;
	assign issue      = (state_q == S_SCAN) && (issue_cnt_q < n_q) && !stop_hit;
	// a read already issued behind a first hit is dropped
	assign eval       = (state_q == S_SCAN) && rd_pend_s1 && !stop_hit;
	assign scan_end   = (state_q == S_SCAN) &&
		(stop_hit || ((issue_cnt_q == n_q) && !rd_pend_s1));
	assign upd        = eval && verdict.fit && verdict.better;
	assign rsp_load   = (state_q == S_RESP) && (!out_vld_q || rsp_ch.ready);

	// entry = {taken, size}
	assign ram_we    = (load_acc && (CW'(req_ch.block_index) < CW'(MAX_BLOCKS))) ||
		((state_q == S_MARK) && found_q);
	assign ram_waddr = (state_q == S_MARK) ? pick_q : IDX_W'(req_ch.block_index);
	assign ram_wdata = (state_q == S_MARK) ? {1'b1, pick_size_q} :
		{1'b0, SIZE_WIDTH'(req_ch.block_size_in)};

	fba_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	fba_fit_unit #(
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_fit (
		.entry_size (ram_rdata[SIZE_WIDTH-1:0]),
		.entry_taken(ram_rdata[SIZE_WIDTH]),
		.req_size   (req_size_q),
		.policy     (policy_q),
		.found      (found_q),
		.best_left  (best_left_q),
		.verdict    (verdict),
		.left       (left)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			policy_q     <= POL_FIRST;
			num_blocks_q <= NUM_BLOCKS_RST;
			lgi_q        <= '0;
			lgv_q        <= 1'b0;
			found_q      <= 1'b0;
			rd_pend_s1   <= 1'b0;
			issue_cnt_q  <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			rd_pend_s1 <= issue;
			if (cfg_we) begin
				unique case (fba_reg_t'(cfg_index))
					REG_POLICY:     policy_q <= fba_policy_t'(cfg_data[1:0]);
					REG_NUM_BLOCKS: num_blocks_q <= cfg_data;
					default:        ;
				endcase
			end
			if (rsp_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q     <= 1'b0;
						issue_cnt_q <= '0;
						state_q     <= (req_ch.req_type == REQ_LOAD) ? S_RESP : S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						issue_cnt_q <= issue_cnt_q + CW'(1);
					end
					if (upd) begin
						found_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= S_MARK;
					end
				end
				S_MARK: begin
					if (found_q) begin
						lgi_q <= BLK_IDX_W'(pick_q);
						lgv_q <= 1'b1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_size_q   <= SIZE_WIDTH'(req_ch.request_size);
			n_q          <= n_calc;
			addr_q       <= (policy_q == POL_NEXT) ? start_addr : '0;
			res_status_q <= STAT_LOADED;
			res_block_q  <= '0;
		end else if (issue) begin
			addr_q <= addr_nxt;
		end
		if (issue) begin
			rd_addr_s1 <= addr_q;
		end
		if (upd) begin
			pick_q      <= rd_addr_s1;
			pick_size_q <= ram_rdata[SIZE_WIDTH-1:0];
			best_left_q <= left;
		end
		if (state_q == S_MARK) begin
			res_status_q <= found_q ? STAT_GRANTED : STAT_MISS;
			res_block_q  <= found_q ? BLK_IDX_W'(pick_q) : '0;
		end
		if (rsp_load) begin
			out_status_q <= res_status_q;
			out_block_q  <= res_block_q;
		end
	end

	assign rsp_ch.valid         = out_vld_q;
	assign rsp_ch.status        = out_status_q;
	assign rsp_ch.granted_block = out_block_q;

	a_rsp_after_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_ch.valid) |-> $past(state_q == S_RESP))
		else $error("response word raised outside the response state");

	a_block_zero_unless_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid && (rsp_ch.status != STAT_GRANTED) |-> (rsp_ch.granted_block == '0))
		else $error("nonzero block index on a load or miss word");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !ram_we)
		else $error("table written during a scan");

	a_scan_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (issue_cnt_q <= n_q))
		else $error("scan read past the blocks in use");

endmodule

FILE: rtl/core/fba_ram.sv
// fba_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fba_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/core/fba_fit_unit.sv
// fba_fit_unit: shared compare unit, judges one table entry per cycle.
// Depends on fba_pkg for the policy codes and the verdict struct.
module fba_fit_unit import fba_pkg::*; #(
	parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
	input  logic [SIZE_WIDTH-1:0] entry_size,
	input  logic                  entry_taken,
	input  logic [SIZE_WIDTH-1:0] req_size,
	input  fba_policy_t           policy,
	input  logic                  found,
	input  logic [SIZE_WIDTH-1:0] best_left,
	output fba_fit_t              verdict,
	output logic [SIZE_WIDTH-1:0] left
);
	always_comb begin
		left = entry_size - req_size;
		verdict.fit = !entry_taken && (entry_size >= req_size);
		// ties keep the entry scanned first (the lower index, but for a wrapped next fit)
		case (policy)
			POL_BEST:  verdict.better = !found || (left < best_left);
			POL_WORST: verdict.better = !found || (left > best_left);
			default:   verdict.better = !found;
		endcase
	end
endmodule

FILE: dv/fba_grant_sb_pkg.sv
`timescale 1ns / 100ps
// fba_grant_sb_pkg: scoreboard for the fit-policy block allocator; predicts each
// response word from a private copy of the block table. Depends on fba_pkg.
package fba_grant_sb_pkg;
	import fba_pkg::*;

	typedef struct {
		fba_status_t          status;
		logic [BLK_IDX_W-1:0] block;
	} grant_word_t;

	class block_grant_scoreboard;
		fba_policy_t          policy;
		int unsigned          num_blocks;
		logic [SIZE_IN_W-1:0] size_tab [MAX_BLOCKS_DEF];
		bit                   taken [MAX_BLOCKS_DEF];
		int unsigned          last_grant;
		bit                   last_grant_valid;
		grant_word_t          pending_grants [$];
		int unsigned          n_loads, n_grants, n_misses, n_checked, n_errors;

		function new();
			policy           = POL_FIRST;
			num_blocks       = 32'(NUM_BLOCKS_RST);
			last_grant       = 0;
			last_grant_valid = 1'b0;
			foreach (taken[k]) begin
				taken[k]    = 1'b0;
				size_tab[k] = '0;
			end
			n_loads   = 0;
			n_grants  = 0;
			n_misses  = 0;
			n_checked = 0;
			n_errors  = 0;
		endfunction

		function void set_reg(fba_reg_t idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_POLICY) begin
				policy = fba_policy_t'(val[1:0]);
			end else begin
				num_blocks = 32'(val);
			end
		endfunction

		function int pending();
			return pending_grants.size();
		endfunction

		function bit slot_fits(int unsigned k, logic [SIZE_IN_W-1:0] req);
			return !taken[k] && (size_tab[k] >= req);
		endfunction

		// Works out the response to one accepted request word and queues it.
		function void note_word(fba_req_t kind, logic [BLK_IDX_W-1:0] idx,
			logic [SIZE_IN_W-1:0] size_in, logic [SIZE_IN_W-1:0] req);
			grant_word_t r;
			int unsigned n, start, s, k, pick, left, best_left;
			bit found;
			n = (num_blocks > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : num_blocks;
			r.status  = STAT_LOADED;
			r.block   = '0;
			found     = 1'b0;
			pick      = 0;
			best_left = 0;
			if (kind == REQ_LOAD) begin
				size_tab[idx] = size_in;
				taken[idx]    = 1'b0;
				n_loads++;
				pending_grants.push_back(r);
				return;
			end
			if (policy == POL_NEXT) begin
				start = (last_grant_valid && last_grant + 1 < n) ? last_grant + 1 : 0;
				for (k = 0; k < n && !found; k++) begin
					s = start + k;
					if (s >= n)
						s -= n;
					if (slot_fits(s, req)) begin
						found = 1'b1;
						pick  = s;
					end
				end
			end else begin
				// first fit never replaces its first candidate
				for (k = 0; k < n; k++) begin
					if (slot_fits(k, req)) begin
						left = size_tab[k] - req;
						if (!found || (policy == POL_BEST && left < best_left) ||
							(policy == POL_WORST && left > best_left)) begin
							found     = 1'b1;
							pick      = k;
							best_left = left;
						end
					end
				end
			end
			if (found) begin
				taken[pick]      = 1'b1;
				last_grant       = pick;
				last_grant_valid = 1'b1;
				r.status         = STAT_GRANTED;
				r.block          = BLK_IDX_W'(pick);
				n_grants++;
			end else begin
				r.status = STAT_MISS;
				n_misses++;
			end
			pending_grants.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			n_errors++;
		endtask

		task check_word(fba_status_t status, logic [BLK_IDX_W-1:0] block);
			grant_word_t e;
			if (pending_grants.size() == 0) begin
				report_mismatch($sformatf("unexpected word status=%0d block=%0d",
					status, block));
				return;
			end
			e = pending_grants.pop_front();
			n_checked++;
			if (status !== e.status)
				report_mismatch($sformatf("word %0d: status %0d, expected %0d",
					n_checked, status, e.status));
			if (block !== e.block)
				report_mismatch($sformatf("word %0d: granted_block %0d, expected %0d",
					n_checked, block, e.block));
		endtask
	endclass

endpackage

FILE: dv/fit_policy_block_allocator_top_tb.sv
`timescale 1ns / 100ps
// fit_policy_block_allocator_top_tb: random and directed test of the allocator
// under all four fit policies. Depends on fba_pkg, fba_ifs, fba_grant_sb_pkg and the top.
module fit_policy_block_allocator_top_tb;
	import fba_pkg::*;
	import fba_grant_sb_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fba_req_if req_ch ();
	fba_rsp_if rsp_ch ();

	fit_policy_block_allocator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_ch    (req_ch),
		.rsp_ch    (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	block_grant_scoreboard sb = new();

	bit [SIZE_IN_W-1:0] slot_size [MAX_BLOCKS_DEF];
	bit                 slot_loaded [MAX_BLOCKS_DEF];
	int unsigned        tx_idle_pct, rx_stall_pct, n_settings, idle_cycles;

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_POLICY;
		cfg_data            = '0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = REQ_LOAD;
		req_ch.block_index  = '0;
		req_ch.block_size_in = '0;
		req_ch.request_size = '0;
		rsp_ch.ready        = 1'b0;
		tx_idle_pct         = 0;
		rx_stall_pct        = 0;
		n_settings          = 0;
		idle_cycles         = 0;
	end

	always #5 clk = ~clk;

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// request words are noted before response words are checked
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			sb.note_word(fba_req_t'(req_ch.req_type), req_ch.block_index,
				req_ch.block_size_in, req_ch.request_size);
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_word(rsp_ch.status, rsp_ch.granted_block);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(fba_req_t kind, logic [BLK_IDX_W-1:0] idx,
		logic [SIZE_IN_W-1:0] size_in, logic [SIZE_IN_W-1:0] req);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= kind;
		req_ch.block_index   <= idx;
		req_ch.block_size_in <= size_in;
		req_ch.request_size  <= req;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		if (kind == REQ_LOAD) begin
			slot_loaded[idx] = 1'b1;
			slot_size[idx]   = size_in;
		end
	endtask

	task automatic load_slot(logic [BLK_IDX_W-1:0] idx, logic [SIZE_IN_W-1:0] size_in);
		send_word(REQ_LOAD, idx, size_in, SIZE_IN_W'($urandom));
	endtask

	task automatic alloc_req(logic [SIZE_IN_W-1:0] req);
		send_word(REQ_ALLOC, BLK_IDX_W'($urandom), SIZE_IN_W'($urandom), req);
	endtask

	// Stops sending and waits until every response has come back.
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(fba_policy_t pol, logic [CFG_DATA_W-1:0] nblk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_POLICY;
		cfg_data  <= CFG_DATA_W'(pol);
		@(negedge clk);
		cfg_index <= REG_NUM_BLOCKS;
		cfg_data  <= nblk;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(REG_POLICY, CFG_DATA_W'(pol));
		sb.set_reg(REG_NUM_BLOCKS, nblk);
		n_settings++;
	endtask

	// Often coarse sizes (multiples of 64) so that best and worst fit see ties.
	function automatic logic [SIZE_IN_W-1:0] pick_size();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			return SIZE_IN_W'($urandom_range(0, 15) * 64);
		else if (sel < 60)
			return SIZE_IN_W'($urandom);
		else if (sel < 70)
			return ($urandom_range(0, 1) != 0) ? '1 : '0;
		else
			return SIZE_IN_W'($urandom_range(0, 4095));
	endfunction

	task automatic run_phase(fba_policy_t pol, logic [CFG_DATA_W-1:0] nblk,
		int unsigned mode, int unsigned count);
		int unsigned n_eff, k, i, sel;
		logic [SIZE_IN_W-1:0] req;
		settle();
		set_config(pol, nblk);
		n_eff = (nblk > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : 32'(nblk);
		case (mode)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 70; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 70; end
			default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
		endcase
		// every scanned slot must hold a size before the first allocate
		for (k = 0; k < n_eff; k++)
			if (!slot_loaded[k])
				load_slot(BLK_IDX_W'(k), pick_size());
		for (i = 0; i < count; i++) begin
			if (i % 40 == 39) begin
				req_ch.valid <= 1'b0;
				do @(negedge clk); while (sb.pending() != 0);
			end
			k = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
			if ($urandom_range(0, 99) < 45) begin
				if (n_eff == 0 || $urandom_range(0, 99) >= 85)
					k = $urandom_range(0, MAX_BLOCKS_DEF - 1);
				load_slot(BLK_IDX_W'(k), pick_size());
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 40)
					req = slot_size[k];
				else if (sel < 70)
					req = SIZE_IN_W'($urandom_range(0, slot_size[k]));
				else if (sel < 85)
					req = SIZE_IN_W'($urandom);
				else
					req = SIZE_IN_W'($urandom_range(0, 255));
				alloc_req(req);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// first fit: zero and full-scale sizes, a slot past num_blocks, a full table
		set_config(POL_FIRST, 4);
		load_slot(0, '0);
		load_slot(1, '1);
		load_slot(2, 100);
		load_slot(3, 100);
		load_slot(63, '1);
		alloc_req('0);
		alloc_req('1);
		alloc_req('1);
		alloc_req(100);
		alloc_req(1);
		alloc_req('0);
		load_slot(0, 50);
		// best fit with a tie
		settle();
		set_config(POL_BEST, 4);
		load_slot(2, 100);
		load_slot(3, 100);
		alloc_req(60);
		alloc_req(10);
		// worst fit with a tie
		settle();
		set_config(POL_WORST, 4);
		load_slot(0, 300);
		load_slot(2, 300);
		alloc_req(1);
		// next fit resumes after a grant made under another policy
		settle();
		set_config(POL_NEXT, 4);
		alloc_req(1);
		alloc_req(1);
		// last grant now lies past num_blocks, so the scan starts at slot 0
		settle();
		set_config(POL_NEXT, 2);
		load_slot(1, 20);
		alloc_req(1);
		settle();
		set_config(POL_FIRST, 0);
		alloc_req('0);

		run_phase(POL_FIRST, 8,   0, 120);
		run_phase(POL_BEST,  8,   1, 120);
		run_phase(POL_WORST, 8,   2, 120);
		run_phase(POL_NEXT,  8,   3, 120);
		run_phase(POL_BEST,  16,  0, 120);
		run_phase(POL_NEXT,  16,  1, 120);
		run_phase(POL_FIRST, 1,   2, 80);
		run_phase(POL_WORST, 64,  3, 80);
		run_phase(POL_NEXT,  127, 0, 100);
		run_phase(POL_BEST,  64,  2, 100);
		run_phase(POL_FIRST, 33,  1, 120);
		run_phase(POL_WORST, 2,   0, 100);
		run_phase(POL_NEXT,  5,   2, 120);
		run_phase(POL_BEST,  0,   3, 60);
		run_phase(POL_WORST, 127, 1, 150);
		run_phase(POL_NEXT,  64,  0, 150);

		settle();
		repeat (72) @(negedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));
		$display("run covered %0d loads, %0d grants and %0d misses over %0d settings",
			sb.n_loads, sb.n_grants, sb.n_misses, n_settings);
		$display("%0d response words checked, %0d mismatches", sb.n_checked, sb.n_errors);
		if (sb.n_errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
